FILE: rtl/core/wpf_pkg.sv
`default_nettype none
package wpf_pkg;

    localparam int WP_DEPTH  = 64;
    localparam int IDX_W     = $clog2(WP_DEPTH);
    localparam int CNT_W     = IDX_W + 1;
    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * DIFF_W;
    localparam int ROOT_W    = DIFF_W + 1;
    localparam int RAM_W     = 3 * COORD_W;
    localparam int ADDR_W    = 4;

    localparam logic [2:0] OP_LOAD    = 3'd0;
    localparam logic [2:0] OP_RESTART = 3'd1;
    localparam logic [2:0] OP_RESUME  = 3'd2;
    localparam logic [2:0] OP_STOP    = 3'd3;
    localparam logic [2:0] OP_TICK    = 3'd4;

    localparam logic [1:0] REG_TOL   = 2'd0;
    localparam logic [1:0] REG_SPEED = 2'd1;
    localparam logic [1:0] REG_LOOP  = 2'd2;
    localparam logic [1:0] REG_COUNT = 2'd3;

    typedef struct packed {
        logic [2:0]               op;
        logic [IDX_W-1:0]         entry_index;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic [15:0]              delta_time;
    } t_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] new_x;
        logic signed [COORD_W-1:0] new_y;
        logic signed [COORD_W-1:0] new_z;
        logic                      moved;
        logic [IDX_W-1:0]          target_index;
        logic                      walking;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_DIFF,
        S_SQUARE,
        S_ROOT,
        S_STEP,
        S_DECIDE,
        S_MUL,
        S_DIV,
        S_ADD,
        S_FIN
    } t_state;

endpackage
`default_nettype wire

FILE: rtl/core/wpf_ram.sv
`default_nettype none
module wpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/core/waypoint_path_follower_top.sv
`default_nettype none
// channel   direction  handshake                payload
// input     in         i_in_valid / o_in_stall  i_in_data  (wpf_pkg::t_in)
// output    out        o_out_valid / i_out_stall o_out_data (wpf_pkg::t_out)
// config    in         APB write/read           paddr, pwdata, prdata
//
// one transaction at a time; load, restart, resume, stop and idle ticks go straight to finish
// a moving tick finds the distance with a bit-serial square root, then arrives or reaches
// the target, or steps partway with one bit-serial divide per axis
// reset clears target index, walk, loop, count; tol, speed = 65536; waypoint ram not cleared
// a finished result waits in the output register while the next transaction is taken
module waypoint_path_follower_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire wpf_pkg::t_in                   i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output wpf_pkg::t_out                       o_out_data,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [wpf_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    // config registers
    logic [30:0]                   r_tol;
    logic [30:0]                   r_speed;
    logic                          r_loop;
    logic [wpf_pkg::CNT_W-1:0]     r_count;
    logic [wpf_pkg::CNT_W-1:0]     w_n;

    // path state
    logic [wpf_pkg::IDX_W-1:0]     r_slot;
    logic                          r_walk;
    wpf_pkg::t_state               r_state, n_state;

    // tick datapath
    logic signed [wpf_pkg::COORD_W-1:0] r_cur [3];
    logic signed [wpf_pkg::DIFF_W-1:0]  r_d   [3];
    logic signed [wpf_pkg::COORD_W-1:0] r_new [3];
    logic                          r_moved;
    logic [15:0]                   r_dt;
    logic [1:0]                    r_axis;
    logic [6:0]                    r_cnt;
    logic [wpf_pkg::SQ_W-1:0]      r_sq;
    logic [35:0]                   r_rem;
    logic [wpf_pkg::ROOT_W-1:0]    r_root;
    logic [30:0]                   r_step;
    logic [63:0]                   r_num;
    logic [wpf_pkg::ROOT_W-1:0]    r_drem;

    wpf_pkg::t_out                 r_out;
    logic                          r_out_valid;

    logic                          w_in_acc;
    logic                          w_cfg_wr;
    logic                          w_tick_go;
    logic                          w_out_free;
    logic                          w_ram_we;
    logic [wpf_pkg::RAM_W-1:0]     w_ram_rd;
    logic [wpf_pkg::DIFF_W-1:0]    w_absd;
    logic [wpf_pkg::SQ_W-1:0]      w_sqp;
    logic [37:0]                   w_rsh;
    logic [37:0]                   w_trial;
    logic                          w_rge;
    logic [46:0]                   w_sp;
    logic [63:0]                   w_prod;
    logic [wpf_pkg::ROOT_W:0]      w_dsh;
    logic                          w_dge;
    logic [wpf_pkg::CNT_W-1:0]     w_next;
    logic [wpf_pkg::COORD_W+1:0]   w_sum;
    logic signed [wpf_pkg::COORD_W-1:0] w_tgt [3];

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;
    assign w_in_acc = i_in_valid & ~o_in_stall;
    assign w_n      = (r_count > wpf_pkg::CNT_W'(wpf_pkg::WP_DEPTH))
                    ? wpf_pkg::CNT_W'(wpf_pkg::WP_DEPTH) : r_count;
    assign w_tick_go = (i_in_data.op == wpf_pkg::OP_TICK) && r_walk && (w_n != '0);
    assign w_out_free = ~r_out_valid | ~i_out_stall;

    // register read back
    always_comb begin
        unique case (paddr[3:2])
            wpf_pkg::REG_TOL:   prdata = {1'b0, r_tol};
            wpf_pkg::REG_SPEED: prdata = {1'b0, r_speed};
            wpf_pkg::REG_LOOP:  prdata = {31'b0, r_loop};
            wpf_pkg::REG_COUNT: prdata = {25'b0, r_count};
            default:            prdata = '0;
        endcase
    end

    // waypoint table: {x, y, z} in one word
    wpf_ram #(
        .WIDTH (wpf_pkg::RAM_W),
        .DEPTH (wpf_pkg::WP_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (i_in_data.entry_index),
        .i_wdata ({i_in_data.coord_x, i_in_data.coord_y, i_in_data.coord_z}),
        .i_raddr (r_slot),
        .o_rdata (w_ram_rd)
    );

    assign w_tgt[0] = w_ram_rd[3*wpf_pkg::COORD_W-1:2*wpf_pkg::COORD_W];
    assign w_tgt[1] = w_ram_rd[2*wpf_pkg::COORD_W-1:wpf_pkg::COORD_W];
    assign w_tgt[2] = w_ram_rd[wpf_pkg::COORD_W-1:0];

    // arithmetic helpers
    assign w_absd  = r_d[r_axis][wpf_pkg::DIFF_W-1] ? wpf_pkg::DIFF_W'(-r_d[r_axis])
                                                   : wpf_pkg::DIFF_W'(r_d[r_axis]);
    assign w_sqp   = w_absd * w_absd;
    // one root bit per cycle
    assign w_rsh   = {r_rem, r_sq[wpf_pkg::SQ_W-1:wpf_pkg::SQ_W-2]};
    assign w_trial = {2'b0, r_root, 2'b01};
    assign w_rge   = w_rsh >= w_trial;
    assign w_sp    = r_speed * r_dt;
    assign w_prod  = w_absd * r_step;
    // one quotient bit per cycle
    assign w_dsh   = {r_drem, r_num[63]};
    assign w_dge   = w_dsh >= {1'b0, r_root};
    assign w_next  = wpf_pkg::CNT_W'(r_slot) + 1'b1;
    assign w_sum   = r_d[r_axis][wpf_pkg::DIFF_W-1]
                   ? ({{2{r_cur[r_axis][wpf_pkg::COORD_W-1]}}, r_cur[r_axis]}
                      - {1'b0, r_num[wpf_pkg::DIFF_W-1:0]})
                   : ({{2{r_cur[r_axis][wpf_pkg::COORD_W-1]}}, r_cur[r_axis]}
                      + {1'b0, r_num[wpf_pkg::DIFF_W-1:0]});

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wpf_pkg::S_IDLE:   if (w_in_acc) begin
                n_state = w_tick_go ? wpf_pkg::S_READ : wpf_pkg::S_FIN;
            end
            wpf_pkg::S_READ:   n_state = wpf_pkg::S_DIFF;
            wpf_pkg::S_DIFF:   n_state = wpf_pkg::S_SQUARE;
            wpf_pkg::S_SQUARE: if (r_axis == 2'd2) begin
                n_state = wpf_pkg::S_ROOT;
            end
            wpf_pkg::S_ROOT:   if (r_cnt == '0) begin
                n_state = wpf_pkg::S_STEP;
            end
            wpf_pkg::S_STEP:   n_state = wpf_pkg::S_DECIDE;
            wpf_pkg::S_DECIDE: begin
                if (r_root < {3'b0, r_tol} || {3'b0, r_step} >= r_root) begin
                    n_state = wpf_pkg::S_FIN;
                end else begin
                    n_state = wpf_pkg::S_MUL;
                end
            end
            wpf_pkg::S_MUL:    n_state = wpf_pkg::S_DIV;
            wpf_pkg::S_DIV:    if (r_cnt == '0) begin
                n_state = wpf_pkg::S_ADD;
            end
            wpf_pkg::S_ADD:    n_state = (r_axis == 2'd2) ? wpf_pkg::S_FIN : wpf_pkg::S_MUL;
            wpf_pkg::S_FIN:    if (w_out_free) begin
                n_state = wpf_pkg::S_IDLE;
            end
            default:           n_state = wpf_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall = (r_state != wpf_pkg::S_IDLE);
        w_ram_we   = w_in_acc && (i_in_data.op == wpf_pkg::OP_LOAD);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wpf_pkg::S_IDLE;
            r_tol       <= 31'd65536;
            r_speed     <= 31'd65536;
            r_loop      <= 1'b0;
            r_count     <= '0;
            r_slot      <= '0;
            r_walk      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_cfg_wr) begin
                unique case (paddr[3:2])
                    wpf_pkg::REG_TOL:   r_tol   <= pwdata[30:0];
                    wpf_pkg::REG_SPEED: r_speed <= pwdata[30:0];
                    wpf_pkg::REG_LOOP:  r_loop  <= pwdata[0];
                    wpf_pkg::REG_COUNT: r_count <= pwdata[wpf_pkg::CNT_W-1:0];
                    default: ;
                endcase
            end

            // command ops settle path state at acceptance
            if (w_in_acc) begin
                case (i_in_data.op)
                    wpf_pkg::OP_RESTART: begin
                        r_slot <= '0;
                        r_walk <= (w_n != '0);
                    end
                    wpf_pkg::OP_RESUME: r_walk <= 1'b1;
                    wpf_pkg::OP_STOP:   r_walk <= 1'b0;
                    wpf_pkg::OP_TICK:   if (w_tick_go && {1'b0, r_slot} >= w_n) begin
                        r_slot <= '0;
                    end
                    default: ;
                endcase
            end

            // arrival inside tolerance
            if (r_state == wpf_pkg::S_DECIDE && r_root < {3'b0, r_tol}) begin
                if (w_next >= w_n) begin
                    if (r_loop) begin
                        r_slot <= '0;
                    end else begin
                        r_walk <= 1'b0;
                    end
                end else begin
                    r_slot <= w_next[wpf_pkg::IDX_W-1:0];
                end
            end

            if (r_state == wpf_pkg::S_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            wpf_pkg::S_IDLE: begin
                r_cur[0] <= i_in_data.coord_x;
                r_cur[1] <= i_in_data.coord_y;
                r_cur[2] <= i_in_data.coord_z;
                r_dt     <= i_in_data.delta_time;
                r_moved  <= 1'b0;
                for (int i = 0; i < 3; i++) begin
                    r_new[i] <= '0;
                end
            end
            wpf_pkg::S_DIFF: begin
                for (int i = 0; i < 3; i++) begin
                    r_d[i] <= {w_tgt[i][wpf_pkg::COORD_W-1], w_tgt[i]}
                            - {r_cur[i][wpf_pkg::COORD_W-1], r_cur[i]};
                end
                r_axis <= 2'd0;
                r_sq   <= '0;
            end
            wpf_pkg::S_SQUARE: begin
                r_sq   <= r_sq + w_sqp;
                r_axis <= r_axis + 2'd1;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= 7'(wpf_pkg::ROOT_W - 2);
            end
            wpf_pkg::S_ROOT: begin
                r_rem  <= w_rge ? 36'(w_rsh - w_trial) : w_rsh[35:0];
                r_root <= {r_root[wpf_pkg::ROOT_W-2:0], w_rge};
                r_sq   <= {r_sq[wpf_pkg::SQ_W-3:0], 2'b00};
                r_cnt  <= r_cnt - 7'd1;
            end
            wpf_pkg::S_STEP: begin
                r_step <= w_sp[46:16];
                r_axis <= 2'd0;
            end
            wpf_pkg::S_DECIDE: begin
                // step reaches the target: land on it
                if (!(r_root < {3'b0, r_tol}) && {3'b0, r_step} >= r_root) begin
                    for (int i = 0; i < 3; i++) begin
                        r_new[i] <= wpf_pkg::COORD_W'(r_cur[i] + r_d[i]);
                    end
                    r_moved <= 1'b1;
                end
            end
            wpf_pkg::S_MUL: begin
                r_num  <= w_prod;
                r_drem <= '0;
                r_cnt  <= 7'd63;
            end
            wpf_pkg::S_DIV: begin
                r_drem <= w_dge ? wpf_pkg::ROOT_W'(w_dsh - {1'b0, r_root})
                                : w_dsh[wpf_pkg::ROOT_W-1:0];
                r_num  <= {r_num[62:0], w_dge};
                r_cnt  <= r_cnt - 7'd1;
            end
            wpf_pkg::S_ADD: begin
                r_new[r_axis] <= w_sum[wpf_pkg::COORD_W-1:0];
                r_moved       <= 1'b1;
                r_axis        <= r_axis + 2'd1;
            end
            wpf_pkg::S_FIN: begin
                if (w_out_free) begin
                    r_out.new_x        <= r_new[0];
                    r_out.new_y        <= r_new[1];
                    r_out.new_z        <= r_new[2];
                    r_out.moved        <= r_moved;
                    r_out.target_index <= r_slot;
                    r_out.walking      <= r_walk;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule
`default_nettype wire
